[sv/kps_pkg.sv]
// Package for the matrix keypad scanner: scan phase type, scan state record,
// register indexes, timing constants and the key character function.
// No dependencies.
`default_nettype none

package kps_pkg;

    localparam int unsigned KPS_ROWS = 4;
    localparam int unsigned KPS_COLS = 3;

    localparam int unsigned ROW_W   = 2;
    localparam int unsigned COL_W   = 2;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DRIVE_W = 3;
    localparam int unsigned POLL_W  = 4;
    localparam int unsigned HOLD_W  = 12;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned ROW_IN_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 2'd2;

    localparam logic [HOLD_W-1:0]  REPEAT_DELAY_RESET = 12'd500;
    localparam logic [POLL_W-1:0]  POLL_TICKS = 4'd10;
    localparam logic [HOLD_W-1:0]  HOLD_STEP  = 12'd10;
    localparam logic [HOLD_W-1:0]  HOLD_MAX   = 12'hFFF;
    localparam logic [DRIVE_W-1:0] ALL_HIGH   = 3'b111;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;
    localparam logic [CODE_W-1:0] CODE_STAR = 4'd10;
    localparam logic [CODE_W-1:0] CODE_ZERO = 4'd11;

    typedef enum logic [1:0] {
        PH_PRE    = 2'd0,
        PH_SETTLE = 2'd1,
        PH_CHECK  = 2'd2,
        PH_HOLD   = 2'd3
    } scan_phase_t;

    typedef struct packed {
        scan_phase_t        phase;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [POLL_W-1:0]  poll;
        logic [HOLD_W-1:0]  hold;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        phase: PH_PRE, col: '0, row: '0, poll: '0, hold: '0
    };

    // Character for a key code. A 4x3 pad uses the telephone layout; other
    // small pads count up from the digit zero, anything larger gives the code.
    function automatic logic [CHAR_W-1:0] key_char_of(
        input logic [CODE_W-1:0] code,
        input int unsigned       rows,
        input int unsigned       cols
    );
        logic [CHAR_W-1:0] ch;
        if (rows == 4 && cols == 3) begin
            if (code < CODE_STAR) begin
                ch = CHAR_ZERO + CHAR_W'(code);
            end else if (code == CODE_STAR) begin
                ch = CHAR_STAR;
            end else if (code == CODE_ZERO) begin
                ch = CHAR_ZERO;
            end else begin
                ch = CHAR_HASH;
            end
        end else if (rows <= 3 && cols <= 3) begin
            ch = CHAR_ZERO + CHAR_W'(code);
        end else begin
            ch = CHAR_W'(code);
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

[sv/kps_tick.sv]
// Per-tick scan logic: next scan state, row search and the result of one tick.
// Purely combinational; depends on kps_pkg.
`default_nettype none

module kps_tick
    import kps_pkg::*;
#(
    parameter int unsigned ROWS = KPS_ROWS,
    parameter int unsigned COLS = KPS_COLS
) (
    input  wire scan_state_t          cur,
    input  wire logic                 scan_enable,
    input  wire logic                 repeat_enable,
    input  wire logic [HOLD_W-1:0]    repeat_delay,
    input  wire logic [ROW_IN_W-1:0]  row_levels,
    output scan_state_t               nxt,
    output logic [DRIVE_W-1:0]        column_drive,
    output logic                      key_valid,
    output logic [CODE_W-1:0]         key_code,
    output logic [CHAR_W-1:0]         key_char
);

    localparam logic [CODE_W-1:0] COLS_CODE = CODE_W'(COLS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);

    logic [ROW_W:0]      search_start;
    logic                found;
    logic [ROW_W-1:0]    found_row;
    logic                do_search;
    logic [POLL_W-1:0]   poll_inc;
    logic [HOLD_W:0]     hold_sum;
    logic [HOLD_W-1:0]   hold_upd;
    logic                hold_end;
    logic [CODE_W-1:0]   code;

    assign search_start = (cur.phase == PH_HOLD) ? ({1'b0, cur.row} + 3'd1) : '0;
    assign poll_inc     = cur.poll + 4'd1;
    assign hold_sum     = {1'b0, cur.hold} + {1'b0, HOLD_STEP};

    always_comb begin
        if (!repeat_enable) begin
            hold_upd = cur.hold;
        end else if (hold_sum[HOLD_W]) begin
            hold_upd = HOLD_MAX;
        end else begin
            hold_upd = hold_sum[HOLD_W-1:0];
        end
    end

    assign hold_end = row_levels[cur.row] || (hold_upd >= repeat_delay);

    // First closed row at or after the start row.
    always_comb begin
        found     = 1'b0;
        found_row = '0;
        for (int r = 0; r < 4; r++) begin
            if (!found && (r < ROWS) && (3'(r) >= search_start) && !row_levels[r]) begin
                found     = 1'b1;
                found_row = ROW_W'(r);
            end
        end
    end

    assign code = CODE_W'(found_row) * COLS_CODE + CODE_W'(cur.col) + 4'd1;

    // Next state.
    always_comb begin
        nxt       = cur;
        do_search = 1'b0;
        if (!scan_enable) begin
            nxt = SCAN_STATE_RESET;
        end else begin
            unique case (cur.phase)
                PH_PRE:    nxt.phase = PH_SETTLE;
                PH_SETTLE: nxt.phase = PH_CHECK;
                PH_CHECK:  do_search = 1'b1;
                PH_HOLD: begin
                    nxt.poll = poll_inc;
                    if (poll_inc >= POLL_TICKS) begin
                        nxt.poll  = '0;
                        nxt.hold  = hold_upd;
                        do_search = hold_end;
                    end
                end
                default: nxt = SCAN_STATE_RESET;
            endcase
            if (do_search) begin
                nxt.poll = '0;
                nxt.hold = '0;
                if (found) begin
                    nxt.phase = PH_HOLD;
                    nxt.row   = found_row;
                end else begin
                    nxt.phase = PH_PRE;
                    nxt.row   = '0;
                    nxt.col   = (cur.col == LAST_COL) ? '0 : cur.col + 2'd1;
                end
            end
        end
    end

    // Result of the tick.
    always_comb begin
        key_valid = do_search && found;
        key_code  = key_valid ? code : '0;
        key_char  = key_valid ? key_char_of(code, ROWS, COLS) : '0;
        if (scan_enable && nxt.phase != PH_PRE) begin
            column_drive = ALL_HIGH & ~(3'b001 << nxt.col);
        end else begin
            column_drive = ALL_HIGH;
        end
    end

endmodule

`default_nettype wire

[sv/matrix_keypad_scanner.sv]
// Matrix keypad scanner top level: configuration registers, tick handshake
// and the result register. Depends on kps_pkg and kps_tick.
//
// Usage. Each beat on the s_ channel is one 1 ms tick carrying the sampled
// row lines (low means closed). Every accepted tick yields exactly one beat
// on the m_ channel: the column lines to drive after that tick and, when a
// key is reported, its code and character. The scan walks the columns with
// a pre-drive tick, a settle tick and a row check, then holds a found key,
// polling every ten ticks until release or the repeat delay.
// A tick accepted at a clock edge has its result on the m_ ports right after
// that edge. Throughput is one tick per cycle, set by the single result
// register; s_ready stays high while the result register is empty or being
// taken in the same cycle. When the receiver stalls, the result is held and
// s_ready drops until it is taken; no tick is lost. Reset clears the scan
// state, leaves the scan and repeat disabled and sets the repeat delay to
// 500 ticks. The user must write configuration through cfg_wr_en, cfg_index
// and cfg_wdata while idle; the block itself does not enforce this.
`default_nettype none

module matrix_keypad_scanner
    import kps_pkg::*;
#(
    parameter int unsigned ROWS = KPS_ROWS,
    parameter int unsigned COLS = KPS_COLS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ROW_IN_W-1:0]   s_row_levels,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DRIVE_W-1:0]         m_column_drive,
    output logic                       m_key_valid,
    output logic [CODE_W-1:0]          m_key_code,
    output logic [CHAR_W-1:0]          m_key_char
);

    logic              scan_enable_reg;
    logic              repeat_enable_reg;
    logic [HOLD_W-1:0] repeat_delay_reg;

    scan_state_t       state_reg;
    scan_state_t       state_next;

    logic               m_valid_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic [DRIVE_W-1:0] drive_next;
    logic               key_valid_reg;
    logic               key_valid_next;
    logic [CODE_W-1:0]  key_code_reg;
    logic [CODE_W-1:0]  key_code_next;
    logic [CHAR_W-1:0]  key_char_reg;
    logic [CHAR_W-1:0]  key_char_next;

    logic accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_enable_reg   <= 1'b0;
            repeat_enable_reg <= 1'b0;
            repeat_delay_reg  <= REPEAT_DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCAN_ENABLE:   scan_enable_reg   <= cfg_wdata[0];
                REG_REPEAT_ENABLE: repeat_enable_reg <= cfg_wdata[0];
                REG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    kps_tick #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_tick (
        .cur           (state_reg),
        .scan_enable   (scan_enable_reg),
        .repeat_enable (repeat_enable_reg),
        .repeat_delay  (repeat_delay_reg),
        .row_levels    (s_row_levels),
        .nxt           (state_next),
        .column_drive  (drive_next),
        .key_valid     (key_valid_next),
        .key_code      (key_code_next),
        .key_char      (key_char_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SCAN_STATE_RESET;
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            state_reg   <= state_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg     <= drive_next;
            key_valid_reg <= key_valid_next;
            key_code_reg  <= key_code_next;
            key_char_reg  <= key_char_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_column_drive = drive_reg;
    assign m_key_valid    = key_valid_reg;
    assign m_key_code     = key_code_reg;
    assign m_key_char     = key_char_reg;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the matrix keypad scanner. Sends tick beats with
// sampled row levels, predicts each result beat and compares it field by field.
// Depends on kps_pkg and matrix_keypad_scanner.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kps_pkg::*;

    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               key_valid;
        logic [CODE_W-1:0]  code;
        logic [CHAR_W-1:0]  ch;
    } key_report_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_SCAN_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [ROW_IN_W-1:0]   s_row_levels = '1;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [DRIVE_W-1:0]    m_column_drive;
    logic                  m_key_valid;
    logic [CODE_W-1:0]     m_key_code;
    logic [CHAR_W-1:0]     m_key_char;

    matrix_keypad_scanner u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scanner state and registers as the predictor sees them.
    logic              scan_on      = 1'b0;
    logic              repeat_on    = 1'b0;
    logic [HOLD_W-1:0] repeat_delay = REPEAT_DELAY_RESET;
    scan_phase_t       phase        = PH_PRE;
    logic [COL_W-1:0]  col          = '0;
    logic [ROW_W-1:0]  held_row     = '0;
    logic [POLL_W-1:0] poll_count   = '0;
    logic [HOLD_W-1:0] held_ms      = '0;

    key_report_t expected_reports[$];
    int          results_pending   = 0;
    int          mismatches        = 0;
    int          snd_idle_pct      = 0;
    int          rcv_idle_pct      = 0;
    int          hold_off_requests = 0;
    int          rcv_seen_requests = 0;
    int          rcv_stall_left    = 0;
    int          quiet_cycles      = 0;

    function automatic void restart_scan();
        phase      = PH_PRE;
        col        = '0;
        held_row   = '0;
        poll_count = '0;
        held_ms    = '0;
    endfunction

    // Looks for the first closed row from first_row on; without one the
    // column is released and the sweep moves to the next column.
    function automatic logic find_key(input int first_row, input logic [ROW_IN_W-1:0] rows,
                                      output logic [CODE_W-1:0] code);
        logic [COL_W-1:0] next_col;
        code = '0;
        for (int r = first_row; r < KPS_ROWS; r++) begin
            if (!rows[r]) begin
                held_row   = ROW_W'(r);
                phase      = PH_HOLD;
                poll_count = '0;
                held_ms    = '0;
                code       = CODE_W'(r * KPS_COLS + int'(col) + 1);
                return 1'b1;
            end
        end
        next_col = (int'(col) + 1 >= KPS_COLS) ? '0 : COL_W'(int'(col) + 1);
        restart_scan();
        col = next_col;
        return 1'b0;
    endfunction

    function automatic key_report_t scan_tick(input logic [ROW_IN_W-1:0] rows);
        key_report_t       res;
        logic [CODE_W-1:0] code;
        int                elapsed;
        res  = '{drive: ALL_HIGH, key_valid: 1'b0, code: '0, ch: '0};
        code = '0;
        if (col >= KPS_COLS) col = '0;
        if (!scan_on) begin
            restart_scan();
        end else begin
            case (phase)
                PH_PRE:    phase = PH_SETTLE;
                PH_SETTLE: phase = PH_CHECK;
                PH_CHECK:  res.key_valid = find_key(0, rows, code);
                default: begin
                    poll_count = poll_count + 1'b1;
                    if (poll_count >= POLL_TICKS) begin
                        poll_count = '0;
                        if (repeat_on) begin
                            elapsed = int'(held_ms) + int'(HOLD_STEP);
                            held_ms = (elapsed > int'(HOLD_MAX)) ? HOLD_MAX : HOLD_W'(elapsed);
                        end
                        if (rows[held_row] || held_ms >= repeat_delay)
                            res.key_valid = find_key(int'(held_row) + 1, rows, code);
                    end
                end
            endcase
            if (phase != PH_PRE) res.drive = ALL_HIGH & ~(DRIVE_W'(1) << col);
        end
        if (res.key_valid) begin
            res.code = code;
            if (code == CODE_STAR) res.ch = CHAR_STAR;
            else if (code == CODE_ZERO) res.ch = CHAR_ZERO;
            else if (code > CODE_ZERO) res.ch = CHAR_HASH;
            else res.ch = CHAR_ZERO + CHAR_W'(code);
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (mismatches < MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin : scoreboard
        key_report_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    note_failure("result beat with no tick outstanding");
                end else begin
                    want = expected_reports.pop_front();
                    if (m_column_drive !== want.drive)
                        note_failure($sformatf("column_drive %b, expected %b",
                                               m_column_drive, want.drive));
                    if (m_key_valid !== want.key_valid)
                        note_failure($sformatf("key_valid %b, expected %b",
                                               m_key_valid, want.key_valid));
                    if (m_key_code !== want.code)
                        note_failure($sformatf("key_code %0d, expected %0d",
                                               m_key_code, want.code));
                    if (m_key_char !== want.ch)
                        note_failure($sformatf("key_char %h, expected %h",
                                               m_key_char, want.ch));
                end
            end
            if (s_valid && s_ready) expected_reports.push_back(scan_tick(s_row_levels));
            // Register writes land at this edge, so they apply from the next tick on.
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SCAN_ENABLE:   scan_on = cfg_wdata[0];
                    REG_REPEAT_ENABLE: repeat_on = cfg_wdata[0];
                    REG_REPEAT_DELAY:  repeat_delay = cfg_wdata;
                    default: ;
                endcase
            end
            results_pending <= expected_reports.size();
        end
    end

    always @(posedge aclk) begin
        if (hold_off_requests != rcv_seen_requests) begin
            rcv_seen_requests = hold_off_requests;
            rcv_stall_left    = HOLD_OFF_CYCLES;
        end
        if (rcv_stall_left > 0) begin
            rcv_stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Valid is left high after a beat; the next call replaces the payload in
    // the same step, so nothing may consume time between two calls.
    task automatic send_tick(input logic [ROW_IN_W-1:0] rows);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_row_levels <= rows;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_rows(input logic [ROW_IN_W-1:0] rows, input int ticks);
        repeat (ticks) send_tick(rows);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // A negative delay leaves the repeat delay register untouched.
    task automatic configure(input logic scan, input logic rpt, input int delay);
        wait_drained();
        repeat (2) @(posedge aclk);
        write_reg(REG_SCAN_ENABLE, CFG_DATA_W'(scan));
        write_reg(REG_REPEAT_ENABLE, CFG_DATA_W'(rpt));
        if (delay >= 0) write_reg(REG_REPEAT_DELAY, CFG_DATA_W'(delay));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idling(input int snd, input int rcv);
        snd_idle_pct = snd;
        rcv_idle_pct <= rcv;
    endtask

    function automatic logic [ROW_IN_W-1:0] random_rows();
        case ($urandom_range(9))
            0, 1, 2, 3: return '1;
            4, 5, 6, 7: return ~(ROW_IN_W'(1) << $urandom_range(KPS_ROWS - 1));
            8: return ~((ROW_IN_W'(1) << $urandom_range(KPS_ROWS - 1)) |
                        (ROW_IN_W'(1) << $urandom_range(KPS_ROWS - 1)));
            default: return ROW_IN_W'($urandom);
        endcase
    endfunction

    task automatic test_scan_disabled();
        set_idling(0, 0);
        send_tick('0);
        send_tick('1);
        send_tick(4'b0101);
        send_tick(4'b1010);
        wait_drained();
    endtask

    // The repeat delay is never written here, so its reset value applies.
    task automatic test_default_repeat_delay();
        configure(1'b1, 1'b1, -1);
        hold_rows('1, 2);
        hold_rows(4'b1110, 520);
        hold_rows('1, 12);
        wait_drained();
    endtask

    // All rows closed with a zero delay: each poll ends the hold, so the
    // sweep walks through every key of every column.
    task automatic test_every_key();
        configure(1'b1, 1'b1, 0);
        hold_rows('0, 140);
        hold_rows('1, 10);
        wait_drained();
    endtask

    task automatic test_release_order();
        configure(1'b1, 1'b0, 10);
        hold_rows('1, 2);
        hold_rows(4'b0101, 25);
        hold_rows(4'b0111, 10);
        hold_rows('1, 25);
        configure(1'b1, 1'b1, 2550);
        hold_rows('1, 2);
        hold_rows(4'b1011, 40);
        hold_rows('1, 15);
        wait_drained();
    endtask

    task automatic test_restart_after_disable();
        configure(1'b1, 1'b0, 10);
        hold_rows('1, 5);
        hold_rows(4'b1101, 15);
        configure(1'b0, 1'b0, 10);
        hold_rows(4'b1101, 3);
        configure(1'b1, 1'b0, 10);
        hold_rows(4'b1101, 25);
        hold_rows('1, 15);
        wait_drained();
    endtask

    task automatic test_result_backpressure();
        set_idling(0, 0);
        configure(1'b1, 1'b1, 10);
        hold_off_requests <= hold_off_requests + 1;
        for (int i = 0; i < 40; i++) send_tick(random_rows());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        int delay;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: set_idling(7, 72);
                1: set_idling(72, 7);
                default: set_idling(0, 0);
            endcase
            for (int part = 0; part < 3; part++) begin
                case ($urandom_range(4))
                    0: delay = 10;
                    1: delay = 2550;
                    2: delay = 0;
                    default: delay = $urandom_range(10, 80);
                endcase
                configure($urandom_range(7) != 0, $urandom_range(1), delay);
                sent = 0;
                while (sent < 20) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 35);
                    hold_rows(random_rows(), len);
                    sent += len;
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_scan_disabled();
        test_default_repeat_delay();
        test_every_key();
        test_release_order();
        test_restart_after_disable();
        test_result_backpressure();
        test_random_traffic();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/kps_pkg.sv
sv/kps_tick.sv
sv/matrix_keypad_scanner.sv
dv/tb.sv
